/* sv/id3fw_pkg.sv */
`default_nettype none

package id3fw_pkg;

    localparam logic [2:0] KIND_TAG_HDR   = 3'd0;
    localparam logic [2:0] KIND_FRAME_HDR = 3'd1;
    localparam logic [2:0] KIND_CHAP_TIME = 3'd2;
    localparam logic [2:0] KIND_BAD_MAGIC = 3'd3;
    localparam logic [2:0] KIND_UNSYNC    = 3'd4;

    localparam logic [31:0] CHAP_DEFAULT  = 32'h4348_4150;
    localparam logic [31:0] TAG_HDR_LEN   = 32'd10;
    localparam logic [31:0] FRAME_HDR_LEN = 32'd10;
    localparam logic [31:0] EXT_HDR_LEN   = 32'd10;

    localparam logic [7:0] MAGIC_0 = 8'h49;
    localparam logic [7:0] MAGIC_1 = 8'h44;
    localparam logic [7:0] MAGIC_2 = 8'h33;

    localparam int UNSYNC_BIT = 7;
    localparam int EXTHDR_BIT = 6;

    localparam logic [7:0] VERSION_4 = 8'd4;

    typedef struct packed {
        logic [7:0]  major_version;
        logic [31:0] frame_offset;
        logic [31:0] value;
        logic [31:0] frame_tag;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0:    m = MAGIC_0;
            2'd1:    m = MAGIC_1;
            default: m = MAGIC_2;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

/* sv/id3fw_parser.sv */
`default_nettype none

module id3fw_parser
    import id3fw_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_restart,
    input  wire logic [31:0]   i_chap_id,
    output logic               o_res_valid,
    output logic [2:0]         o_res_kind,
    output t_result            o_res
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FRAME,
        PH_CHAP_ELEM,
        PH_CHAP_TIME,
        PH_SKIP,
        PH_DONE
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [3:0]  r_cnt,      n_cnt;
    logic [31:0] r_pos,      n_pos;
    logic [31:0] r_tag_end,  n_tag_end;
    logic [7:0]  r_ver,      n_ver;
    logic [31:0] r_id,       n_id;
    logic [31:0] r_acc,      n_acc;
    logic [31:0] r_begin,    n_begin;
    logic [31:0] r_skip,     n_skip;

    t_phase      c_phase;
    logic [3:0]  c_cnt;
    logic [31:0] c_pos, c_tag_end, c_id, c_acc, c_begin, c_skip;
    logic [7:0]  c_ver;
    logic        mismatch;
    logic [31:0] acc7, acc8, frame_sz;

    always_comb begin
        c_phase   = i_restart ? PH_HEADER : r_phase;
        c_cnt     = i_restart ? 4'd0  : r_cnt;
        c_pos     = i_restart ? 32'd0 : r_pos;
        c_tag_end = i_restart ? 32'd0 : r_tag_end;
        c_ver     = i_restart ? 8'd0  : r_ver;
        c_id      = i_restart ? 32'd0 : r_id;
        c_acc     = i_restart ? 32'd0 : r_acc;
        c_begin   = i_restart ? 32'd0 : r_begin;
        c_skip    = i_restart ? 32'd0 : r_skip;

        if (c_phase == PH_SKIP && c_pos >= c_skip) begin
            c_phase = PH_FRAME;
            c_cnt   = 4'd0;
        end

        n_phase   = c_phase;
        n_cnt     = c_cnt;
        n_pos     = c_pos + 32'd1;
        n_tag_end = c_tag_end;
        n_ver     = c_ver;
        n_id      = c_id;
        n_acc     = c_acc;
        n_begin   = c_begin;
        n_skip    = c_skip;

        mismatch  = (i_byte != magic_byte(c_cnt[1:0]));
        acc7      = {c_acc[24:0], 7'd0} + {24'd0, i_byte};
        acc8      = {c_acc[23:0], i_byte};
        frame_sz  = (c_ver == VERSION_4) ? acc7 : acc8;

        o_res_valid         = 1'b0;
        o_res_kind          = KIND_TAG_HDR;
        o_res.major_version = c_ver;
        o_res.frame_offset  = 32'd0;
        o_res.value         = 32'd0;
        o_res.frame_tag     = 32'd0;

        unique case (c_phase)
            PH_HEADER: begin
                if (c_cnt < 4'd3) begin
                    if (c_cnt == 4'd2 && (mismatch || c_acc != 32'd0)) begin
                        o_res_valid = 1'b1;
                        o_res_kind  = KIND_BAD_MAGIC;
                        n_phase     = PH_DONE;
                        n_acc       = 32'd1;
                    end else begin
                        if (mismatch) n_acc = 32'd1;
                        n_cnt = c_cnt + 4'd1;
                    end
                end else if (c_cnt == 4'd3) begin
                    n_ver = i_byte;
                    n_cnt = c_cnt + 4'd1;
                end else if (c_cnt == 4'd4) begin
                    n_cnt = c_cnt + 4'd1;
                end else if (c_cnt == 4'd5) begin
                    if (i_byte[UNSYNC_BIT]) begin
                        o_res_valid = 1'b1;
                        o_res_kind  = KIND_UNSYNC;
                        n_phase     = PH_DONE;
                    end else begin
                        n_skip = {31'd0, i_byte[EXTHDR_BIT]};
                        n_acc  = 32'd0;
                        n_cnt  = c_cnt + 4'd1;
                    end
                end else begin
                    n_acc = acc7;
                    if (c_cnt == 4'd9) begin
                        o_res_valid = 1'b1;
                        o_res_kind  = KIND_TAG_HDR;
                        o_res.value = acc7;
                        n_tag_end   = TAG_HDR_LEN + acc7;
                        if (c_skip != 32'd0) begin
                            n_skip  = TAG_HDR_LEN + EXT_HDR_LEN;
                            n_phase = PH_SKIP;
                        end else begin
                            n_phase = PH_FRAME;
                        end
                        n_cnt = 4'd0;
                    end else begin
                        n_cnt = c_cnt + 4'd1;
                    end
                end
            end
            PH_FRAME: begin
                if (c_cnt == 4'd0) begin
                    if (c_pos >= c_tag_end || i_byte == 8'd0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_begin = c_pos;
                        n_id    = {24'd0, i_byte};
                        n_cnt   = 4'd1;
                    end
                end else if (c_cnt < 4'd4) begin
                    n_id = {c_id[23:0], i_byte};
                    if (c_cnt == 4'd3) n_acc = 32'd0;
                    n_cnt = c_cnt + 4'd1;
                end else if (c_cnt < 4'd8) begin
                    n_acc = frame_sz;
                    n_cnt = c_cnt + 4'd1;
                end else if (c_cnt == 4'd8) begin
                    n_cnt = c_cnt + 4'd1;
                end else begin
                    o_res_valid        = 1'b1;
                    o_res_kind         = KIND_FRAME_HDR;
                    o_res.frame_tag    = c_id;
                    o_res.value        = c_acc;
                    o_res.frame_offset = c_begin;
                    n_skip  = c_begin + FRAME_HDR_LEN + c_acc;
                    n_phase = (c_id == i_chap_id) ? PH_CHAP_ELEM : PH_SKIP;
                    n_cnt   = 4'd0;
                end
            end
            PH_CHAP_ELEM: begin
                if (i_byte == 8'd0) begin
                    n_phase = PH_CHAP_TIME;
                    n_cnt   = 4'd0;
                    n_acc   = 32'd0;
                end
            end
            PH_CHAP_TIME: begin
                n_acc = acc8;
                if (c_cnt >= 4'd3) begin
                    o_res_valid        = 1'b1;
                    o_res_kind         = KIND_CHAP_TIME;
                    o_res.frame_tag    = c_id;
                    o_res.value        = acc8;
                    o_res.frame_offset = c_begin;
                    n_phase = PH_SKIP;
                    n_cnt   = 4'd0;
                end else begin
                    n_cnt = c_cnt + 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_cnt     <= 4'd0;
            r_pos     <= 32'd0;
            r_tag_end <= 32'd0;
            r_ver     <= 8'd0;
            r_id      <= 32'd0;
            r_acc     <= 32'd0;
            r_begin   <= 32'd0;
            r_skip    <= 32'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_pos     <= n_pos;
            r_tag_end <= n_tag_end;
            r_ver     <= n_ver;
            r_id      <= n_id;
            r_acc     <= n_acc;
            r_begin   <= n_begin;
            r_skip    <= n_skip;
        end
    end

endmodule

`default_nettype wire

/* sv/id3fw_out_reg.sv */
`default_nettype none

module id3fw_out_reg
    import id3fw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire logic [2:0] i_kind,
    input  wire t_result    i_res,
    input  wire logic       i_ready,
    output logic            o_free,
    output logic            o_valid,
    output logic [2:0]      o_kind,
    output t_result         o_res
);

    logic       r_valid;
    logic [2:0] r_kind;
    t_result    r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_kind <= i_kind;
            r_res  <= i_res;
        end
    end

endmodule

`default_nettype wire

/* sv/id3fw_tb_free_top_placeholder.sv */
`default_nettype none

module id3fw_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_restart,
    input  wire logic       i_take,
    output logic            o_ready,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_restart
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_restart;

    assign o_ready   = !r_valid || i_take;
    assign o_valid   = r_valid;
    assign o_byte    = r_byte;
    assign o_restart = r_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte    <= i_byte;
            r_restart <= i_restart;
        end
    end

endmodule

`default_nettype wire

/* sv/id3v2_frame_walker_unit.sv */
// Channel   Dir  Beat contents (low bit first)
// s_axis    in   tdata: data_byte[7:0]; tuser: restart[0]
// m_axis    out  tdata: frame_tag, value, frame_offset, major_version; tuser: kind
// cfg       in   chapter_frame_id, written when i_cfg_we is high
//
// One byte per cycle sustained while m_axis is ready; a byte's result enters the result register
// when the parser steps on that byte from the input register.
// Reset clears the parser and sets chapter_frame_id to "CHAP".
// A stalled result holds the parser; one further byte waits in the input register.
`default_nettype none

module id3v2_frame_walker_unit
    import id3fw_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [31:0]   i_cfg_wdata,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [7:0]    i_s_tdata,   // data_byte
    input  wire logic [0:0]    i_s_tuser,   // restart
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [103:0]       o_m_tdata,   // frame_tag, value, frame_offset, major_version
    output logic [2:0]         o_m_tuser    // kind
);

    logic [31:0] r_chap_id;
    logic        out_free, in_valid, in_restart, res_valid;
    logic [7:0]  in_byte;
    logic [2:0]  res_kind;
    t_result     res, out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chap_id <= CHAP_DEFAULT;
        end else if (i_cfg_we) begin
            r_chap_id <= i_cfg_wdata;
        end
    end

    id3fw_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_byte    (i_s_tdata),
        .i_restart (i_s_tuser[0]),
        .i_take    (out_free),
        .o_ready   (o_s_tready),
        .o_valid   (in_valid),
        .o_byte    (in_byte),
        .o_restart (in_restart)
    );

    id3fw_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_valid && out_free),
        .i_byte      (in_byte),
        .i_restart   (in_restart),
        .i_chap_id   (r_chap_id),
        .o_res_valid (res_valid),
        .o_res_kind  (res_kind),
        .o_res       (res)
    );

    id3fw_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_valid && res_valid),
        .i_kind  (res_kind),
        .i_res   (res),
        .i_ready (i_m_tready),
        .o_free  (out_free),
        .o_valid (o_m_tvalid),
        .o_kind  (o_m_tuser),
        .o_res   (out_res)
    );

    assign o_m_tdata = {out_res.major_version, out_res.frame_offset,
                        out_res.value, out_res.frame_tag};

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser <= KIND_UNSYNC))
        else $error("result kind out of range");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && !out_free) |=> in_valid)
        else $error("pending byte dropped during stall");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == KIND_BAD_MAGIC || o_m_tuser == KIND_UNSYNC))
        |-> (o_m_tdata[95:0] == 96'd0))
        else $error("error result carries nonzero fields");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
